[rtl/avsdbf_pkg.sv]
`default_nettype none

package avsdbf_pkg;

    // boundary strength codes
    localparam logic [1:0] BS_NONE   = 2'd0;
    localparam logic [1:0] BS_NORMAL = 2'd1;
    localparam logic [1:0] BS_STRONG = 2'd2;

    typedef logic [7:0]         sample_t;
    typedef logic signed [11:0] tap_sum_t;
    typedef logic signed [8:0]  delta_t;

    // |a - b| on 8-bit samples
    function automatic sample_t abs_diff(input sample_t a, input sample_t b);
        sample_t r;
        r = (a >= b) ? (a - b) : (b - a);
        return r;
    endfunction

    // 3*(a - b) + c - d + 4, range -1016..1024
    function automatic tap_sum_t tap_sum(input sample_t a, input sample_t b,
                                         input sample_t c, input sample_t d);
        tap_sum_t df;
        tap_sum_t r;
        df = $signed({4'b0, a}) - $signed({4'b0, b});
        r  = (df <<< 1) + df + $signed({4'b0, c}) - $signed({4'b0, d})
             + 12'sd4;
        return r;
    endfunction

    // sample plus a signed correction, saturated to 0..255
    function automatic sample_t add_sat(input sample_t s, input delta_t d);
        logic signed [9:0] t;
        sample_t r;
        t = $signed({2'b0, s}) + $signed({d[8], d});
        if (t < 10'sd0)
            r = 8'd0;
        else if (t > 10'sd255)
            r = 8'd255;
        else
            r = t[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/avsdbf_clip_delta.sv]
`default_nettype none

module avsdbf_clip_delta
(
    input  wire avsdbf_pkg::tap_sum_t raw,
    input  wire avsdbf_pkg::sample_t  clip,
    output avsdbf_pkg::delta_t        delta
);
    import avsdbf_pkg::*;

    delta_t shifted;
    delta_t pos_lim;
    delta_t neg_lim;
    tap_sum_t shifted_full;

    // floor division by 8
    assign shifted_full = raw >>> 3;
    assign shifted      = shifted_full[8:0];
    assign pos_lim      = $signed({1'b0, clip});
    assign neg_lim      = -pos_lim;

    always_comb
    begin
        if (shifted > pos_lim)
            delta = pos_lim;
        else if (shifted < neg_lim)
            delta = neg_lim;
        else
            delta = shifted;
    end

endmodule

`default_nettype wire

[rtl/avs_deblocking_edge_filter.sv]
`default_nettype none

// channel | signals                                             | accepted when
// --------+-----------------------------------------------------+----------------------
// in      | in_valid in_ready sample_p2..sample_q2 edge_strength | in_valid && in_ready
//         | alpha_limit beta_limit clip_limit is_chroma           |
//         | last_in_segment                                       |
// out     | out_valid out_ready out_p1 out_p0 out_q0 out_q1       | out_valid && out_ready
//         | out_last                                              |
//
// four register stages a to d, one item per cycle while out_ready holds high;
// an item passes stages a, b, c, d in order; the last stage register is the output register
// stage depth is set by the activity test in stage a and by the clip and
// saturating add in stages b and d
// rst_n clears only the stage valid bits; payload registers are not reset
// each stage holds while it is full and the stage after it cannot take, so an
// empty stage ahead of a stall still fills; nothing is dropped or repeated

module avs_deblocking_edge_filter
(
    input  wire                  clk,
    input  wire                  rst_n,

    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire avsdbf_pkg::sample_t sample_p2,
    input  wire avsdbf_pkg::sample_t sample_p1,
    input  wire avsdbf_pkg::sample_t sample_p0,
    input  wire avsdbf_pkg::sample_t sample_q0,
    input  wire avsdbf_pkg::sample_t sample_q1,
    input  wire avsdbf_pkg::sample_t sample_q2,
    input  wire [1:0]            edge_strength,
    input  wire avsdbf_pkg::sample_t alpha_limit,
    input  wire avsdbf_pkg::sample_t beta_limit,
    input  wire avsdbf_pkg::sample_t clip_limit,
    input  wire                  is_chroma,
    input  wire                  last_in_segment,

    output logic                 out_valid,
    input  wire                  out_ready,
    output avsdbf_pkg::sample_t  out_p1,
    output avsdbf_pkg::sample_t  out_p0,
    output avsdbf_pkg::sample_t  out_q0,
    output avsdbf_pkg::sample_t  out_q1,
    output logic                 out_last
);
    import avsdbf_pkg::*;

    // stage a: activity test, strong filter done, first tap sum
    typedef struct packed {
        sample_t  p2, p1, p0, q0, q1, q2;
        sample_t  res_p1, res_p0, res_q0, res_q1;
        logic     use_normal;
        logic     upd_p1;
        logic     upd_q1;
        tap_sum_t sum0;
        sample_t  clip;
        logic     last;
    } stage_a_t;

    // stage b: normal filter p0/q0 done
    typedef struct packed {
        sample_t p2, p1, q1, q2;
        sample_t np0, nq0;
        sample_t res_p1, res_p0, res_q0, res_q1;
        logic    upd_p1;
        logic    upd_q1;
        sample_t clip;
        logic    last;
    } stage_b_t;

    // stage c: second tap sums for p1/q1
    typedef struct packed {
        sample_t  res_p1, res_p0, res_q0, res_q1;
        logic     upd_p1;
        logic     upd_q1;
        tap_sum_t sum_p;
        tap_sum_t sum_q;
        sample_t  clip;
        logic     last;
    } stage_c_t;

    // stage d: output register
    typedef struct packed {
        sample_t res_p1, res_p0, res_q0, res_q1;
        logic    last;
    } stage_d_t;

    logic     a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic     a_ready, b_ready, c_ready, d_ready;
    stage_a_t a_reg, a_next;
    stage_b_t b_reg, b_next;
    stage_c_t c_reg, c_next;
    stage_d_t d_reg, d_next;

    // ---------------- handshake: a stage loads when empty or draining
    assign d_ready   = !d_valid_reg || out_ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = d_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
            a_reg <= a_next;
        if (b_ready)
            b_reg <= b_next;
        if (c_ready)
            c_reg <= c_next;
        if (d_ready)
            d_reg <= d_next;
    end

    // ---------------- stage a logic
    sample_t     d_pq, d_pp1, d_qq1, d_pp2, d_qq2;
    sample_t     inner_lim;
    logic        active;
    logic        side_p_ok, side_q_ok;
    logic        strong_p, strong_q;
    logic [9:0]  avg_base;
    logic [9:0]  p_near, p_far, q_near, q_far;

    always_comb
    begin
        d_pq  = abs_diff(sample_p0, sample_q0);
        d_pp1 = abs_diff(sample_p1, sample_p0);
        d_qq1 = abs_diff(sample_q1, sample_q0);
        d_pp2 = abs_diff(sample_p2, sample_p0);
        d_qq2 = abs_diff(sample_q2, sample_q0);

        active    = (d_pq < alpha_limit) && (d_pp1 < beta_limit) && (d_qq1 < beta_limit);
        side_p_ok = d_pp2 < beta_limit;
        side_q_ok = d_qq2 < beta_limit;
        inner_lim = {2'b0, alpha_limit[7:2]} + 8'd2;
        strong_p  = side_p_ok && (d_pq < inner_lim);
        strong_q  = side_q_ok && (d_pq < inner_lim);

        // strong averaging terms, all fit in 10 bits
        avg_base = {2'b0, sample_p0} + {2'b0, sample_q0} + 10'd2;
        p_near   = {2'b0, sample_p1} + {2'b0, sample_p0} + avg_base;
        p_far    = {1'b0, sample_p1, 1'b0} + avg_base;
        q_near   = {2'b0, sample_q1} + {2'b0, sample_q0} + avg_base;
        q_far    = {1'b0, sample_q1, 1'b0} + avg_base;

        a_next.p2   = sample_p2;
        a_next.p1   = sample_p1;
        a_next.p0   = sample_p0;
        a_next.q0   = sample_q0;
        a_next.q1   = sample_q1;
        a_next.q2   = sample_q2;
        a_next.sum0 = tap_sum(sample_q0, sample_p0, sample_p1, sample_q1);
        a_next.clip = clip_limit;
        a_next.last = last_in_segment;

        // pass-through by default
        a_next.res_p1     = sample_p1;
        a_next.res_p0     = sample_p0;
        a_next.res_q0     = sample_q0;
        a_next.res_q1     = sample_q1;
        a_next.use_normal = 1'b0;
        a_next.upd_p1     = 1'b0;
        a_next.upd_q1     = 1'b0;

        if (active)
        begin
            unique case (edge_strength)
                BS_NONE:
                begin
                end
                BS_STRONG:
                begin
                    a_next.res_p0 = strong_p ? p_near[9:2] : p_far[9:2];
                    a_next.res_q0 = strong_q ? q_near[9:2] : q_far[9:2];
                    if (strong_p && !is_chroma)
                        a_next.res_p1 = p_far[9:2];
                    if (strong_q && !is_chroma)
                        a_next.res_q1 = q_far[9:2];
                end
                default:
                begin
                    // normal filter, also taken for the undefined strength code
                    a_next.use_normal = 1'b1;
                    a_next.upd_p1     = !is_chroma && side_p_ok;
                    a_next.upd_q1     = !is_chroma && side_q_ok;
                end
            endcase
        end
    end

    // ---------------- stage b logic: first clipped delta
    delta_t d0;

    avsdbf_clip_delta u_delta0
    (
        .raw   (a_reg.sum0),
        .clip  (a_reg.clip),
        .delta (d0)
    );

    always_comb
    begin
        b_next.p2     = a_reg.p2;
        b_next.p1     = a_reg.p1;
        b_next.q1     = a_reg.q1;
        b_next.q2     = a_reg.q2;
        b_next.np0    = add_sat(a_reg.p0, d0);
        b_next.nq0    = add_sat(a_reg.q0, -d0);
        b_next.res_p1 = a_reg.res_p1;
        b_next.res_q1 = a_reg.res_q1;
        b_next.res_p0 = a_reg.use_normal ? b_next.np0 : a_reg.res_p0;
        b_next.res_q0 = a_reg.use_normal ? b_next.nq0 : a_reg.res_q0;
        b_next.upd_p1 = a_reg.upd_p1;
        b_next.upd_q1 = a_reg.upd_q1;
        b_next.clip   = a_reg.clip;
        b_next.last   = a_reg.last;
    end

    // ---------------- stage c logic: luma p1/q1 tap sums
    always_comb
    begin
        c_next.res_p1 = b_reg.res_p1;
        c_next.res_p0 = b_reg.res_p0;
        c_next.res_q0 = b_reg.res_q0;
        c_next.res_q1 = b_reg.res_q1;
        c_next.upd_p1 = b_reg.upd_p1;
        c_next.upd_q1 = b_reg.upd_q1;
        c_next.sum_p  = tap_sum(b_reg.np0, b_reg.p1, b_reg.p2, b_reg.nq0);
        c_next.sum_q  = tap_sum(b_reg.q1, b_reg.nq0, b_reg.np0, b_reg.q2);
        c_next.clip   = b_reg.clip;
        c_next.last   = b_reg.last;
    end

    // ---------------- stage d logic: clipped p1/q1 corrections
    delta_t dp, dq;

    avsdbf_clip_delta u_delta_p
    (
        .raw   (c_reg.sum_p),
        .clip  (c_reg.clip),
        .delta (dp)
    );

    avsdbf_clip_delta u_delta_q
    (
        .raw   (c_reg.sum_q),
        .clip  (c_reg.clip),
        .delta (dq)
    );

    always_comb
    begin
        d_next.res_p0 = c_reg.res_p0;
        d_next.res_q0 = c_reg.res_q0;
        d_next.res_p1 = c_reg.upd_p1 ? add_sat(c_reg.res_p1, dp) : c_reg.res_p1;
        d_next.res_q1 = c_reg.upd_q1 ? add_sat(c_reg.res_q1, -dq) : c_reg.res_q1;
        d_next.last   = c_reg.last;
    end

    assign out_p1   = d_reg.res_p1;
    assign out_p0   = d_reg.res_p0;
    assign out_q0   = d_reg.res_q0;
    assign out_q1   = d_reg.res_q1;
    assign out_last = d_reg.last;

endmodule

`default_nettype wire
